// File: src/led_sequencer_long_press_mode_top_defines.svh
// Assertion macros used by the checker file of the LED sequencer.
`ifndef LED_SEQUENCER_LONG_PRESS_MODE_TOP_DEFINES_SVH
`define LED_SEQUENCER_LONG_PRESS_MODE_TOP_DEFINES_SVH

// Concurrent assertion, sampled on clk_i and idle while rst_ni is low.
`define LSLPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define LSLPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/lslpm_pkg.sv
// Types and constants of the LED sequencer with long-press blink mode.
package lslpm_pkg;

  localparam int unsigned PeriodW  = 16;
  localparam int unsigned HoldCntW = 17;
  localparam int unsigned HoldNumW = 4;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PhaseW-1:0] NormalLast = PhaseW'(6 - 1);
  localparam logic [PhaseW-1:0] BlinkLast  = PhaseW'(2 - 1);

  localparam logic [PhaseW-1:0] PhaseRedA  = 3'd0;
  localparam logic [PhaseW-1:0] PhaseRedB  = 3'd2;
  localparam logic [PhaseW-1:0] PhaseGreen = 3'd4;

  localparam logic [PeriodW-1:0]  RedPeriodRst   = 16'd5999;
  localparam logic [PeriodW-1:0]  GreenPeriodRst = 16'd10900;
  localparam logic [PeriodW-1:0]  DarkPeriodRst  = 16'd5999;
  localparam logic [PeriodW-1:0]  BlinkPeriodRst = 16'd5999;
  localparam logic [PeriodW-1:0]  HoldHalfRst    = 16'd24999;
  localparam logic [HoldNumW-1:0] HoldPeriodsRst = 4'd5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RED_PERIOD   = 3'd0,
    REG_GREEN_PERIOD = 3'd1,
    REG_DARK_PERIOD  = 3'd2,
    REG_BLINK_PERIOD = 3'd3,
    REG_HOLD_HALF    = 3'd4,
    REG_HOLD_PERIODS = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PeriodW-1:0]  red_period;
    logic [PeriodW-1:0]  green_period;
    logic [PeriodW-1:0]  dark_period;
    logic [PeriodW-1:0]  blink_period;
    logic [PeriodW-1:0]  hold_half_period;
    logic [HoldNumW-1:0] hold_periods;
  } cfg_t;

  typedef struct packed {
    logic slow_tick;
    logic fast_tick;
    logic button_down;
  } in_t;

  typedef struct packed {
    logic blink_mode;
    logic green_lit;
    logic red_on;
  } res_t;

endpackage

// File: src/lslpm_core.sv
// Phase sequencer and button hold timer state, updated once per accepted word.
module lslpm_core
  import lslpm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  in_t  in_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  logic                mode_q, mode_d;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [PeriodW-1:0]  ticks_q, ticks_d;
  logic                press_q, press_d;
  logic [HoldCntW-1:0] hold_q, hold_d;
  logic [HoldNumW-1:0] elapsed_q, elapsed_d;

  logic [PeriodW-1:0]  period;
  logic [PhaseW-1:0]   last_phase;
  logic [HoldCntW-1:0] hold_next;
  logic [HoldCntW-1:0] hold_limit;
  logic [HoldNumW-1:0] elapsed_next;

  always_comb begin
    if (mode_q) begin
      period = cfg_i.blink_period;
    end else if (phase_q == PhaseRedA || phase_q == PhaseRedB) begin
      period = cfg_i.red_period;
    end else if (phase_q == PhaseGreen) begin
      period = cfg_i.green_period;
    end else begin
      period = cfg_i.dark_period;
    end
  end

  assign last_phase   = mode_q ? BlinkLast : NormalLast;
  assign hold_next    = hold_q + HoldCntW'(1);
  assign hold_limit   = {cfg_i.hold_half_period, 1'b0};
  assign elapsed_next = elapsed_q + HoldNumW'(1);

  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    press_d   = press_q;
    hold_d    = hold_q;
    elapsed_d = elapsed_q;

    // advance the phase timer
    if (in_i.slow_tick) begin
      if (ticks_q >= period) begin
        ticks_d = '0;
        phase_d = (phase_q >= last_phase) ? '0 : phase_q + PhaseW'(1);
      end else begin
        ticks_d = ticks_q + PeriodW'(1);
      end
    end

    if (mode_q) begin
      if (!in_i.button_down) begin
        mode_d  = 1'b0;
        phase_d = '0;
        ticks_d = '0;
      end
    end else if (in_i.button_down) begin
      if (!press_q) begin
        press_d   = 1'b1;
        hold_d    = '0;
        elapsed_d = '0;
      end else if (in_i.fast_tick) begin
        if (hold_next >= hold_limit) begin
          hold_d    = '0;
          elapsed_d = elapsed_next;
          if (elapsed_next == cfg_i.hold_periods) begin
            press_d   = 1'b0;
            elapsed_d = '0;
            mode_d    = 1'b1;
            phase_d   = '0;
            ticks_d   = '0;
          end
        end else begin
          hold_d = hold_next;
        end
      end
    end else begin
      press_d   = 1'b0;
      hold_d    = '0;
      elapsed_d = '0;
    end

    res_o.blink_mode = mode_d;
    if (mode_d) begin
      res_o.red_on    = (phase_d == PhaseRedA);
      res_o.green_lit = (phase_d == PhaseRedA);
    end else begin
      res_o.red_on    = (phase_d == PhaseRedA) || (phase_d == PhaseRedB);
      res_o.green_lit = (phase_d == PhaseGreen);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      phase_q   <= '0;
      ticks_q   <= '0;
      press_q   <= 1'b0;
      hold_q    <= '0;
      elapsed_q <= '0;
    end else if (en_i) begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      ticks_q   <= ticks_d;
      press_q   <= press_d;
      hold_q    <= hold_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

// File: src/led_sequencer_long_press_mode_top.sv
// Two-LED sequencer top level: one input word in, one LED state word out, one word per
// clock cycle unless the output is stalled. Each accepted word carries slow tick, fast
// tick and button level; the phase timer and the hold timer are updated in the same
// cycle and the resulting LED state is registered in the output stage. The output
// register is the only stage, so input is taken whenever it is empty or being drained.
module led_sequencer_long_press_mode_top
  import lslpm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [0] slow_tick, [1] fast_tick, [2] button_down
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [0] red_on, [1] green_lit, [2] blink_mode
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;
  in_t  in_word;
  res_t res;
  res_t res_q;
  logic out_valid_q;
  logic accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_word.slow_tick   = s_axis_tdata[0];
  assign in_word.fast_tick   = s_axis_tdata[1];
  assign in_word.button_down = s_axis_tdata[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_period       <= RedPeriodRst;
      cfg_q.green_period     <= GreenPeriodRst;
      cfg_q.dark_period      <= DarkPeriodRst;
      cfg_q.blink_period     <= BlinkPeriodRst;
      cfg_q.hold_half_period <= HoldHalfRst;
      cfg_q.hold_periods     <= HoldPeriodsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RED_PERIOD:   cfg_q.red_period       <= cfg_data_i;
        REG_GREEN_PERIOD: cfg_q.green_period     <= cfg_data_i;
        REG_DARK_PERIOD:  cfg_q.dark_period      <= cfg_data_i;
        REG_BLINK_PERIOD: cfg_q.blink_period     <= cfg_data_i;
        REG_HOLD_HALF:    cfg_q.hold_half_period <= cfg_data_i;
        REG_HOLD_PERIODS: cfg_q.hold_periods     <= cfg_data_i[HoldNumW-1:0];
        default: ;
      endcase
    end
  end

  lslpm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .in_i   (in_word),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.blink_mode, res_q.green_lit, res_q.red_on};

endmodule

// File: src/lslpm_checker.sv
// Port-level checks of the LED sequencer, bound to its top level.
`include "led_sequencer_long_press_mode_top_defines.svh"

module lslpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  `LSLPM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
  `LSLPM_ASSERT_ALWAYS(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output stage")
  `LSLPM_ASSERT(a_accept_gives_word, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "accepted word produced no output word")
  `LSLPM_ASSERT(a_led_pattern, m_axis_tvalid |-> (m_axis_tdata[2] ? (m_axis_tdata[0] == m_axis_tdata[1]) : !(m_axis_tdata[0] && m_axis_tdata[1])), "illegal LED pattern for mode")

endmodule

bind led_sequencer_long_press_mode_top lslpm_checker u_lslpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: test/led_sequencer_long_press_mode_tb.sv
// Stream testbench for the LED sequencer with long-press blink mode: directed and random traffic.
`timescale 1ns / 100ps

module tb;
  import lslpm_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;  // [0] slow_tick, [1] fast_tick, [2] button_down
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;       // [0] red_on, [1] green_lit, [2] blink_mode
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  led_sequencer_long_press_mode_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Sequencer copy kept by the testbench
  cfg_t                cfg_q;
  logic                blink_q;
  logic [PhaseW-1:0]   phase_q;
  logic [PeriodW-1:0]  ticks_q;
  logic                pressed_q;
  logic [HoldCntW-1:0] hold_ticks_q;
  logic [HoldNumW-1:0] hold_count_q;

  res_t        led_expected[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;

  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_cycle = 0;
  logic [7:0]  rx_pattern = 8'hA5;

  res_t seen_word;
  res_t due_word;

  function automatic res_t led_state_after(input in_t w);
    logic [PhaseW-1:0]  last;
    logic [PeriodW-1:0] period;
    int unsigned        next_hold;
    int unsigned        hold_span;
    res_t               r;
    last = blink_q ? BlinkLast : NormalLast;
    if (blink_q) period = cfg_q.blink_period;
    else if (phase_q == PhaseRedA || phase_q == PhaseRedB) period = cfg_q.red_period;
    else if (phase_q == PhaseGreen) period = cfg_q.green_period;
    else period = cfg_q.dark_period;

    if (w.slow_tick) begin
      if (ticks_q >= period) begin
        ticks_q = '0;
        phase_q = (phase_q >= last) ? PhaseRedA : phase_q + 1'b1;
      end else begin
        ticks_q = ticks_q + 1'b1;
      end
    end

    if (blink_q) begin
      if (!w.button_down) begin
        blink_q = 1'b0;
        phase_q = PhaseRedA;
        ticks_q = '0;
      end
    end else if (w.button_down) begin
      if (!pressed_q) begin
        pressed_q    = 1'b1;
        hold_ticks_q = '0;
        hold_count_q = '0;
      end else if (w.fast_tick) begin
        next_hold = hold_ticks_q + 1;
        hold_span = 2 * cfg_q.hold_half_period;
        if (next_hold >= hold_span) begin
          hold_ticks_q = '0;
          hold_count_q = hold_count_q + 1'b1;
          if (hold_count_q == cfg_q.hold_periods) begin
            pressed_q    = 1'b0;
            hold_count_q = '0;
            blink_q      = 1'b1;
            phase_q      = PhaseRedA;
            ticks_q      = '0;
          end
        end else begin
          hold_ticks_q = next_hold[HoldCntW-1:0];
        end
      end
    end else begin
      pressed_q    = 1'b0;
      hold_ticks_q = '0;
      hold_count_q = '0;
    end

    if (blink_q) begin
      r.red_on    = (phase_q == PhaseRedA);
      r.green_lit = r.red_on;
    end else begin
      r.red_on    = (phase_q == PhaseRedA || phase_q == PhaseRedB);
      r.green_lit = (phase_q == PhaseGreen);
    end
    r.blink_mode = blink_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < 40)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_word = res_t'(m_axis_tdata[2:0]);
      if (led_expected.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(seen_word), 0);
      end else begin
        due_word = led_expected.pop_front();
        if (seen_word.red_on !== due_word.red_on)
          report_mismatch("red_on", 32'(seen_word.red_on), 32'(due_word.red_on));
        if (seen_word.green_lit !== due_word.green_lit)
          report_mismatch("green_lit", 32'(seen_word.green_lit), 32'(due_word.green_lit));
        if (seen_word.blink_mode !== due_word.blink_mode)
          report_mismatch("blink_mode", 32'(seen_word.blink_mode), 32'(due_word.blink_mode));
      end
    end
  end

  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 53 == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 2));
      rx_pattern = 8'($urandom) | 8'h01;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:   m_axis_tready <= rx_pattern[3'(rx_cycle % 8)];
    endcase
  end

  task automatic send_word(input in_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, w.button_down, w.fast_tick, w.slow_tick};
    do @(posedge clk_i); while (!s_axis_tready);
    led_expected.push_back(led_state_after(w));
    burst_left--;
  endtask

  task automatic send_bits(input logic slow, input logic fast, input logic down);
    in_t w;
    w.slow_tick   = slow;
    w.fast_tick   = fast;
    w.button_down = down;
    send_word(w);
  endtask

  // Waits until no output word is pending, then leaves the block idle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (led_expected.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RED_PERIOD:   cfg_q.red_period       = val;
      REG_GREEN_PERIOD: cfg_q.green_period     = val;
      REG_DARK_PERIOD:  cfg_q.dark_period      = val;
      REG_BLINK_PERIOD: cfg_q.blink_period     = val;
      REG_HOLD_HALF:    cfg_q.hold_half_period = val;
      REG_HOLD_PERIODS: cfg_q.hold_periods     = val[HoldNumW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CfgDataW-1:0] red, input logic [CfgDataW-1:0] green,
                                input logic [CfgDataW-1:0] dark, input logic [CfgDataW-1:0] blink,
                                input logic [CfgDataW-1:0] half, input logic [CfgDataW-1:0] hold);
    wait_idle();
    write_reg(REG_RED_PERIOD, red);
    write_reg(REG_GREEN_PERIOD, green);
    write_reg(REG_DARK_PERIOD, dark);
    write_reg(REG_BLINK_PERIOD, blink);
    write_reg(REG_HOLD_HALF, half);
    write_reg(REG_HOLD_PERIODS, hold);
  endtask

  // Mostly presses, some long enough to reach blink mode, then releases; some noise.
  task automatic press_traffic(input int unsigned n);
    int unsigned sent;
    int unsigned hp;
    int unsigned per;
    int unsigned need;
    int unsigned len;
    int unsigned fast_pct;
    int unsigned slow_pct;
    sent = 0;
    while (sent < n) begin
      slow_pct = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(0, 80);
      if ($urandom_range(0, 3) != 0) begin
        hp       = (cfg_q.hold_periods == 0) ? 16 : cfg_q.hold_periods;
        per      = (cfg_q.hold_half_period == 0) ? 1 : 2 * cfg_q.hold_half_period;
        need     = hp * per;
        fast_pct = $urandom_range(60, 100);
        len      = (need > 150) ? $urandom_range(1, 60)
                                : 1 + $urandom_range(need / 2, need * 100 / fast_pct + 3);
        repeat (len) begin
          send_bits($urandom_range(1, 100) <= slow_pct, $urandom_range(1, 100) <= fast_pct, 1'b1);
          sent++;
        end
        len = $urandom_range(1, 5);
        repeat (len) begin
          send_bits($urandom_range(1, 100) <= slow_pct, 1'($urandom_range(0, 1)), 1'b0);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          send_bits(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  task automatic test_after_reset();
    send_bits(1'b1, 1'b1, 1'b0);
    send_bits(1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_phase_walk();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
    repeat (6) send_bits(1'b1, 1'b0, 1'b0);
  endtask

  // Lower the period while a phase is running; it must end at the next slow tick.
  task automatic test_period_lowered();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
    send_bits(1'b1, 1'b0, 1'b0);
    send_bits(1'b1, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_RED_PERIOD, 16'd1);
    send_bits(1'b1, 1'b0, 1'b0);
  endtask

  // Zero half period and zero hold count: sixteen fast ticks enter blink mode.
  task automatic test_hold_wrap();
    wait_idle();
    write_reg(REG_HOLD_HALF, 16'd0);
    write_reg(REG_HOLD_PERIODS, 16'd0);
    send_bits(1'b0, 1'b0, 1'b1);
    repeat (16) send_bits(1'b0, 1'b1, 1'b1);
    send_bits(1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_spare_index();
    apply_settings(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(1, 2)), 16'($urandom_range(1, 3)));
    write_reg(RegSpareA, 16'h0000);
    write_reg(RegSpareB, 16'hFFFF);
    press_traffic(250);
  endtask

  task automatic test_extreme_settings();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    press_traffic(150);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    press_traffic(60);
  endtask

  task automatic test_random_press();
    apply_settings(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                   16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                   16'($urandom_range(0, 3)), 16'($urandom_range(0, 15)));
    press_traffic(250);
    apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 4)),
                   16'($urandom_range(1, 3)), 16'($urandom_range(1, 4)));
    press_traffic(150);
    apply_settings(16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                   16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                   16'($urandom_range(1, 2)), 16'($urandom_range(1, 2)));
    press_traffic(200);
  endtask

  initial begin
    cfg_q.red_period       = RedPeriodRst;
    cfg_q.green_period     = GreenPeriodRst;
    cfg_q.dark_period      = DarkPeriodRst;
    cfg_q.blink_period     = BlinkPeriodRst;
    cfg_q.hold_half_period = HoldHalfRst;
    cfg_q.hold_periods     = HoldPeriodsRst;
    blink_q      = 1'b0;
    phase_q      = PhaseRedA;
    ticks_q      = '0;
    pressed_q    = 1'b0;
    hold_ticks_q = '0;
    hold_count_q = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_phase_walk();
    test_period_lowered();
    test_hold_wrap();
    test_spare_index();
    test_extreme_settings();
    test_random_press();

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
